[rtl/assert_macros.svh]
// Assertion helpers shared by the pcd_front and pcd_queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define PCD_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("pcd assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define PCD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcd assertion failed");

`endif

[rtl/pcd_pkg.sv]
package pcd_pkg;

    typedef enum logic [7:0] {
        PH_CNT_LO = 8'b0000_0001,
        PH_CNT_HI = 8'b0000_0010,
        PH_SKIP   = 8'b0000_0100,
        PH_COPY   = 8'b0000_1000,
        PH_RED    = 8'b0001_0000,
        PH_GREEN  = 8'b0010_0000,
        PH_BLUE   = 8'b0100_0000,
        PH_IDLE   = 8'b1000_0000
    } pcd_phase_t;

    // Highest value the true palette index is allowed to reach.
    localparam logic [8:0] POS_SAT = 9'd256;

    // One classified result on its way from the parser to the output stage.
    // Components are still raw bytes here; scaling happens in the back end.
    typedef struct packed {
        logic       is_write;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       index_overflow;
        logic       chunk_done;
    } pcd_item_t;

endpackage

[rtl/pcd_front.sv]
module pcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              chunk_start,
    output logic              push,
    output pcd_pkg::pcd_item_t push_item
);
    import pcd_pkg::*;

    pcd_phase_t  phase_reg, phase_next;
    logic [15:0] packets_left_reg, packets_left_next;
    logic [8:0]  copies_left_reg, copies_left_next;
    logic [8:0]  position_reg, position_next;
    logic [7:0]  wrap_position_reg, wrap_position_next;
    logic [7:0]  held_red_reg, held_red_next;
    logic [7:0]  held_green_reg, held_green_next;
    logic [7:0]  count_low_reg, count_low_next;

    // State as seen by this byte, after an optional chunk restart.
    pcd_phase_t  phase_eff;
    logic [15:0] packets_eff;
    logic [8:0]  copies_eff;
    logic [8:0]  position_eff;
    logic [7:0]  wrap_eff;
    logic [7:0]  red_eff;
    logic [7:0]  green_eff;
    logic [9:0]  pos_sum;
    logic [7:0]  advance_amt;
    logic [8:0]  copies_dec;
    logic        last;

    always_comb begin
        phase_eff    = phase_reg;
        packets_eff  = packets_left_reg;
        copies_eff   = copies_left_reg;
        position_eff = position_reg;
        wrap_eff     = wrap_position_reg;
        red_eff      = held_red_reg;
        green_eff    = held_green_reg;
        if (chunk_start) begin
            phase_eff    = PH_CNT_LO;
            packets_eff  = '0;
            copies_eff   = '0;
            position_eff = '0;
            wrap_eff     = '0;
            red_eff      = '0;
            green_eff    = '0;
        end

        advance_amt = (phase_eff == PH_BLUE) ? 8'd1 : data_byte;
        pos_sum     = {1'b0, position_eff} + {2'b00, advance_amt};
        copies_dec  = copies_eff - 9'd1;
        last        = (copies_dec == 9'd0) && (packets_eff == 16'd0);

        phase_next         = phase_eff;
        packets_left_next  = packets_eff;
        copies_left_next   = copies_eff;
        position_next      = position_eff;
        wrap_position_next = wrap_eff;
        held_red_next      = red_eff;
        held_green_next    = green_eff;
        count_low_next     = count_low_reg;
        push               = 1'b0;
        push_item          = '0;

        case (phase_eff)
            PH_CNT_LO: begin
                count_low_next = data_byte;
                phase_next     = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                packets_left_next = {data_byte, count_low_reg};
                if ({data_byte, count_low_reg} == 16'd0) begin
                    phase_next           = PH_IDLE;
                    push                 = 1'b1;
                    push_item.chunk_done = 1'b1;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                packets_left_next  = packets_eff - 16'd1;
                position_next      = (pos_sum > {1'b0, POS_SAT}) ? POS_SAT : pos_sum[8:0];
                wrap_position_next = wrap_eff + data_byte;
                phase_next         = PH_COPY;
            end
            PH_COPY: begin
                // A copy count of zero stands for a full run of 256 entries.
                copies_left_next = (data_byte == 8'd0) ? POS_SAT : {1'b0, data_byte};
                phase_next       = PH_RED;
            end
            PH_RED: begin
                held_red_next = data_byte;
                phase_next    = PH_GREEN;
            end
            PH_GREEN: begin
                held_green_next = data_byte;
                phase_next      = PH_BLUE;
            end
            PH_BLUE: begin
                push                     = 1'b1;
                push_item.is_write       = 1'b1;
                push_item.entry_index    = wrap_eff;
                push_item.red            = red_eff;
                push_item.green          = green_eff;
                push_item.blue           = data_byte;
                push_item.index_overflow = (position_eff > 9'd255);
                push_item.chunk_done     = last;
                position_next      = (pos_sum > {1'b0, POS_SAT}) ? POS_SAT : pos_sum[8:0];
                wrap_position_next = wrap_eff + 8'd1;
                copies_left_next   = copies_dec;
                if (last) begin
                    phase_next = PH_IDLE;
                end else if (copies_dec == 9'd0) begin
                    phase_next = PH_SKIP;
                end else begin
                    phase_next = PH_RED;
                end
            end
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (!in_fire) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_CNT_LO;
            packets_left_reg  <= '0;
            copies_left_reg   <= '0;
            position_reg      <= '0;
            wrap_position_reg <= '0;
            held_red_reg      <= '0;
            held_green_reg    <= '0;
            count_low_reg     <= '0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            packets_left_reg  <= packets_left_next;
            copies_left_reg   <= copies_left_next;
            position_reg      <= position_next;
            wrap_position_reg <= wrap_position_next;
            held_red_reg      <= held_red_next;
            held_green_reg    <= held_green_next;
            count_low_reg     <= count_low_next;
        end
    end

`include "assert_macros.svh"

    `PCD_ASSERT_ALWAYS(a_pos_saturates, aclk, aresetn, position_reg <= POS_SAT)
    `PCD_ASSERT_IMPLIES(a_copies_live, aclk, aresetn, (phase_reg == PH_RED) || (phase_reg == PH_GREEN) || (phase_reg == PH_BLUE), copies_left_reg != 9'd0)

endmodule

[rtl/pcd_queue.sv]
module pcd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pcd_pkg::pcd_item_t push_item,
    output logic               in_ready,
    input  logic               pop,
    output logic               out_valid,
    output pcd_pkg::pcd_item_t out_item
);
    import pcd_pkg::*;

    pcd_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "assert_macros.svh"

    `PCD_ASSERT_ALWAYS(a_no_overfill, aclk, aresetn, !(push && !in_ready))
    `PCD_ASSERT_ALWAYS(a_no_underrun, aclk, aresetn, !(pop && !out_valid))
    `PCD_ASSERT_IMPLIES(a_ptr_match, aclk, aresetn, (count_reg == 2'd0) || (count_reg == 2'd2), wr_ptr_reg == rd_ptr_reg)

endmodule

[rtl/pcd_back.sv]
module pcd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               q_valid,
    input  pcd_pkg::pcd_item_t q_item,
    output logic               pop,
    input  logic               m_ready,
    output logic               m_valid,
    output pcd_pkg::pcd_item_t m_item
);
    import pcd_pkg::*;

    logic      six_bit_reg;
    logic      m_valid_reg, m_valid_next;
    pcd_item_t m_item_reg, m_item_next;

    function automatic logic [7:0] scale(input logic [7:0] v, input logic six);
        scale = six ? {v[5:0], 2'b00} : v;
    endfunction

    assign pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_item_next       = q_item;
        m_item_next.red   = scale(q_item.red, six_bit_reg);
        m_item_next.green = scale(q_item.green, six_bit_reg);
        m_item_next.blue  = scale(q_item.blue, six_bit_reg);
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            six_bit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                six_bit_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[rtl/palette_chunk_decoder.sv]
// A result goes from the queue entry through the output register to the m_ ports.
// Throughput: one byte per cycle while s_ready is high; parser state updates per byte.
// A two-entry queue between parser and output register absorbs result-side stalls; s_ready
// drops only while that queue is full.
// Reset (synchronous, aresetn low): parser awaits a count low byte, queue and output empty,
// six-bit component mode off.
module palette_chunk_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_chunk_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_write,
    output logic [7:0] m_entry_index,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic       m_index_overflow,
    output logic       m_chunk_done
);
    import pcd_pkg::*;

    logic      in_fire;
    logic      push;
    logic      pop;
    logic      q_valid;
    pcd_item_t push_item;
    pcd_item_t q_item;
    pcd_item_t m_item;

    assign in_fire = s_valid && s_ready;

    pcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_data_byte),
        .chunk_start (s_chunk_start),
        .push        (push),
        .push_item   (push_item)
    );

    pcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .in_ready  (s_ready),
        .pop       (pop),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    pcd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_item      (m_item)
    );

    assign m_is_write       = m_item.is_write;
    assign m_entry_index    = m_item.entry_index;
    assign m_red            = m_item.red;
    assign m_green          = m_item.green;
    assign m_blue           = m_item.blue;
    assign m_index_overflow = m_item.index_overflow;
    assign m_chunk_done     = m_item.chunk_done;

endmodule
